// ===== rtl/bvd_pkg.sv =====
// ----------------------------------------------------------------------------
// bvd_pkg
// Shared types, constants and code-table functions for the Bayer VLC/DPCM
// frame decoder.
// ----------------------------------------------------------------------------
package bvd_pkg;

  localparam int MaxWidth   = 1024;
  localparam int HeightCap  = 1024;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(HeightCap);
  localparam int AddrW      = ColW + 1;
  localparam int CfgW       = 11;
  localparam int BufW       = 15;
  localparam int CntW       = 4;

  localparam logic [CfgW-1:0] WidthReset  = 11'd352;
  localparam logic [CfgW-1:0] HeightReset = 11'd288;
  localparam logic [CfgW-1:0] WidthMin    = 11'd4;
  localparam logic [CfgW-1:0] WidthMax    = 11'(MaxWidth);
  localparam logic [CfgW-1:0] HeightMin   = 11'd2;
  localparam logic [CfgW-1:0] HeightMax   = 11'(HeightCap);

  // register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CntW-1:0]  len;
    logic signed [8:0] delta;
    logic             absolute;
    logic             unk;
  } code_t;

  // 8-bit window at the top of the bit buffer, zero filled below the count
  function automatic logic [7:0] head_window(input logic [BufW-1:0] bits,
                                             input logic [CntW-1:0] cnt);
    logic [BufW+7:0] x;
    x = {bits, 8'h00} >> cnt;
    return x[7:0];
  endfunction

  function automatic code_t decode_code(input logic [7:0] h, input logic raw);
    code_t c;
    c.len      = 4'd8;
    c.delta    = 9'sd0;
    c.absolute = 1'b0;
    c.unk      = 1'b0;
    if (raw) begin
      c.delta    = $signed({1'b0, h});
      c.absolute = 1'b1;
    end else if ((h & 8'h80) == 8'h00) begin
      c.len = 4'd1;
    end else if ((h & 8'hE0) == 8'h80) begin
      c.len = 4'd3; c.delta = 9'sd4;
    end else if ((h & 8'hE0) == 8'hA0) begin
      c.len = 4'd3; c.delta = -9'sd4;
    end else if ((h & 8'hF0) == 8'hD0) begin
      c.len = 4'd4; c.delta = 9'sd11;
    end else if ((h & 8'hF0) == 8'hF0) begin
      c.len = 4'd4; c.delta = -9'sd11;
    end else if ((h & 8'hF8) == 8'hC8) begin
      c.len = 4'd5; c.delta = 9'sd20;
    end else if ((h & 8'hFC) == 8'hC0) begin
      c.len = 4'd6; c.delta = -9'sd20;
    end else if ((h & 8'hFC) == 8'hC4) begin
      c.unk = 1'b1;
    end else if ((h & 8'hF0) == 8'hE0) begin
      c.delta    = $signed({1'b0, h[3:0], 4'h0});
      c.absolute = 1'b1;
    end
    return c;
  endfunction

endpackage

// ===== rtl/bayer_vlc_dpcm_decoder_core.sv =====
// ----------------------------------------------------------------------------
// bayer_vlc_dpcm_decoder_core
// Decodes a compressed Bayer bit stream, one byte per request, into 8-bit
// pixels in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one stream byte per request;
//   in_frame_start restarts at row 0 with an empty bit buffer. The result
//   channel (out_valid/out_stall) carries one pixel per request with its
//   unknown-code, frame-end and last-of-byte flags.
//   cfg_we/cfg_index/cfg_wdata write image width and height; write only
//   while the decoder is idle.
// Timing:
//   One code is decoded per cycle while the output is not stalled; a pixel
//   appears in the output register in the cycle after its decode. A byte
//   occupies the decoder until every pixel it completes is decoded. The next
//   byte is taken in the cycle its predecessor's last pixel is decoded. The
//   rate is set by the line store: one read of the pixel two rows up and one
//   write-back per cycle.
// Reset: clears position, bit buffer and flags; registers go to 352 x 288.
//   The line store is not cleared.
// Stall: a stalled output holds its pixel and the decoder holds its state;
//   in_stall stays high until the current byte is used up.
// ----------------------------------------------------------------------------
module bayer_vlc_dpcm_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_stream_byte,
  input  logic       in_frame_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_pixel,
  output logic       out_unknown_code,
  output logic       out_frame_end,
  output logic       out_last
);

  localparam int ColW  = bvd_pkg::ColW;
  localparam int RowW  = bvd_pkg::RowW;
  localparam int AddrW = bvd_pkg::AddrW;
  localparam int CfgW  = bvd_pkg::CfgW;
  localparam int BufW  = bvd_pkg::BufW;
  localparam int CntW  = bvd_pkg::CntW;

  // configuration
  logic [CfgW-1:0] width_r, height_r;
  logic [CfgW-1:0] weff, heff;

  // decode state
  logic [BufW-1:0] bbuf_r, bbuf_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [RowW-1:0] row_r, row_nxt;
  logic [ColW-1:0] col_r, col_nxt;
  logic [15:0]     left_r, left_nxt;
  logic            busy_r, busy_nxt;

  // output register
  logic       oval_r;
  logic [7:0] opix_r;
  logic       ounk_r, oend_r, olast_r;

  // line store
  logic [7:0] line_mem [0:(1<<AddrW)-1];
  logic [7:0] top_r;

  bvd_pkg::code_t cd, cd_n;
  logic [7:0]      head;
  logic            raw, fits;
  logic [CntW-1:0] cnt_c;
  logic [BufW-1:0] bbuf_c;
  logic [7:0]      left2, pix;
  logic [8:0]      avg_sum;
  logic [7:0]      base;
  logic signed [10:0] val;
  logic            col_wrap, row_last, fend;
  logic [RowW-1:0] row_n;
  logic [ColW-1:0] col_n;
  logic            raw_n, more;
  logic            out_free, adv, done, in_acc;
  logic [BufW-1:0] base_bbuf;
  logic [CntW-1:0] base_cnt;
  logic [BufW+7:0] app;

  always_comb begin
    weff = width_r;
    if (width_r < bvd_pkg::WidthMin) weff = bvd_pkg::WidthMin;
    if (width_r > bvd_pkg::WidthMax) weff = bvd_pkg::WidthMax;
    heff = height_r;
    if (height_r < bvd_pkg::HeightMin) heff = bvd_pkg::HeightMin;
    if (height_r > bvd_pkg::HeightMax) heff = bvd_pkg::HeightMax;
  end

  always_comb begin
    head   = bvd_pkg::head_window(bbuf_r, cnt_r);
    raw    = (row_r < RowW'(2)) && (col_r < ColW'(2));
    cd     = bvd_pkg::decode_code(head, raw);
    fits   = (cd.len <= cnt_r);
    cnt_c  = cnt_r - cd.len;
    bbuf_c = bbuf_r & ~({BufW{1'b1}} << cnt_c);

    // predictor: top in the first two columns, left in the first two rows, else their average
    left2   = left_r[15:8];
    avg_sum = {1'b0, top_r} + {1'b0, left2};
    if (col_r < ColW'(2))      base = top_r;
    else if (row_r < RowW'(2)) base = left2;
    else                       base = avg_sum[8:1];

    if (cd.absolute) val = 11'(cd.delta);
    else             val = $signed({3'b000, base}) + 11'(cd.delta);
    if (val < 11'sd0)        pix = 8'd0;
    else if (val > 11'sd255) pix = 8'd255;
    else                     pix = val[7:0];

    col_wrap = ({1'b0, col_r} + 11'd1) >= weff;
    row_last = ({1'b0, row_r} + 11'd1) >= heff;
    fend     = col_wrap && row_last;
    col_n    = col_wrap ? '0 : col_r + ColW'(1);
    row_n    = row_r;
    if (col_wrap) row_n = row_last ? '0 : row_r + RowW'(1);

    // look ahead: does the following code complete in the bits left over
    raw_n = (row_n < RowW'(2)) && (col_n < ColW'(2));
    cd_n  = bvd_pkg::decode_code(bvd_pkg::head_window(bbuf_c, cnt_c), raw_n);
    more  = !fend && (cd_n.len <= cnt_c);

    out_free = !oval_r || !out_stall;
    adv      = busy_r && fits && out_free;
    done     = !busy_r || !fits || (out_free && !more);
    in_acc   = in_valid && done;
  end

  assign in_stall = !done;

  always_comb begin
    base_bbuf = bbuf_r;
    base_cnt  = cnt_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    left_nxt  = left_r;
    if (adv) begin
      if (fend) begin
        base_bbuf = '0;
        base_cnt  = '0;
        row_nxt   = '0;
        col_nxt   = '0;
        left_nxt  = '0;
      end else begin
        base_bbuf = bbuf_c;
        base_cnt  = cnt_c;
        row_nxt   = row_n;
        col_nxt   = col_n;
        left_nxt  = {left_r[7:0], pix};
      end
    end
    if (in_acc && in_frame_start) begin
      base_bbuf = '0;
      base_cnt  = '0;
      row_nxt   = '0;
      col_nxt   = '0;
      left_nxt  = '0;
    end
    app      = {base_bbuf, 8'h00} | {{BufW{1'b0}}, in_stream_byte};
    bbuf_nxt = in_acc ? app[BufW-1:0] : base_bbuf;
    cnt_nxt  = in_acc ? base_cnt + CntW'(8) : base_cnt;
    busy_nxt = in_acc ? 1'b1 : (adv ? more : (busy_r && fits));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bvd_pkg::WidthReset;
      height_r <= bvd_pkg::HeightReset;
      bbuf_r   <= '0;
      cnt_r    <= '0;
      row_r    <= '0;
      col_r    <= '0;
      left_r   <= '0;
      busy_r   <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bvd_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
          bvd_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        endcase
      end
      bbuf_r <= bbuf_nxt;
      cnt_r  <= cnt_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      left_r <= left_nxt;
      busy_r <= busy_nxt;
      if (adv) begin
        oval_r <= 1'b1;
      end else if (!out_stall) begin
        oval_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (adv) begin
      opix_r  <= pix;
      ounk_r  <= cd.unk;
      oend_r  <= fend;
      olast_r <= !more;
    end
  end

  // line store: write back the current pixel, read ahead at the next position
  always_ff @(posedge clk) begin
    if (adv) begin
      line_mem[{row_r[0], col_r}] <= pix;
    end
    top_r <= line_mem[{row_nxt[0], col_nxt}];
  end

  assign out_valid        = oval_r;
  assign out_pixel        = opix_r;
  assign out_unknown_code = ounk_r;
  assign out_frame_end    = oend_r;
  assign out_last         = olast_r;

endmodule

// ===== tb/tb_bayer_vlc_dpcm_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_bayer_vlc_dpcm_decoder_core
// Self-checking bench for the Bayer VLC/DPCM frame decoder. Stream bytes are
// built from code sequences (plus random noise), fed through a queue-driven
// driver with random gaps, and every decoded pixel is checked in order against
// a built-in decoder model. Frame geometry is reprogrammed between phases,
// including out-of-range and mid-frame values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bayer_vlc_dpcm_decoder_core;

  typedef struct packed {
    logic [7:0] data;
    logic       fs;
  } byte_req_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       unk;
    logic       fend;
    logic       last;
  } pixel_rec_t;

  typedef enum int {
    CODE_ZERO, CODE_PLUS4, CODE_MINUS4, CODE_PLUS11, CODE_MINUS11,
    CODE_PLUS20, CODE_MINUS20, CODE_UNKNOWN, CODE_ABS
  } code_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = bvd_pkg::REG_IMAGE_WIDTH;
  logic [10:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_stream_byte = '0;
  logic        in_frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_pixel;
  logic        out_unknown_code;
  logic        out_frame_end;
  logic        out_last;

  bayer_vlc_dpcm_decoder_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel        (out_pixel),
    .out_unknown_code (out_unknown_code),
    .out_frame_end    (out_frame_end),
    .out_last         (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // decoder model state
  logic [bvd_pkg::CfgW-1:0] width_reg  = bvd_pkg::WidthReset;
  logic [bvd_pkg::CfgW-1:0] height_reg = bvd_pkg::HeightReset;
  logic [7:0]               line_mem [0:2*bvd_pkg::MaxWidth-1];
  logic [bvd_pkg::BufW-1:0] bits_held  = '0;
  logic [bvd_pkg::CntW-1:0] bits_avail = '0;
  logic [bvd_pkg::RowW-1:0] row_pos    = '0;
  logic [bvd_pkg::ColW-1:0] col_pos    = '0;
  logic [15:0]              left_pair  = '0;

  byte_req_t  byte_pending [$];
  pixel_rec_t pixel_expected [$];
  bit         stream_bits [$];

  byte_req_t drv_item;
  logic      req_taken = 1'b0;
  int        bytes_done = 0;
  int        bytes_queued = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        hold_left = 0;
  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;
  bit        calm = 1'b0;
  int        fail_count = 0;

  function automatic int eff_width(input logic [bvd_pkg::CfgW-1:0] w);
    if (w < bvd_pkg::WidthMin) return int'(bvd_pkg::WidthMin);
    if (w > bvd_pkg::WidthMax) return int'(bvd_pkg::WidthMax);
    return int'(w);
  endfunction

  function automatic int eff_height(input logic [bvd_pkg::CfgW-1:0] h);
    if (h < bvd_pkg::HeightMin) return int'(bvd_pkg::HeightMin);
    if (h > bvd_pkg::HeightMax) return int'(bvd_pkg::HeightMax);
    return int'(h);
  endfunction

  task automatic restart_position();
    bits_held  = '0;
    bits_avail = '0;
    row_pos    = '0;
    col_pos    = '0;
    left_pair  = '0;
  endtask

  // Decode one stream byte and queue the pixels it completes.
  task automatic decode_request(input byte_req_t req);
    logic [7:0]                head;
    logic [7:0]                pix;
    logic [bvd_pkg::AddrW-1:0] idx;
    int              len, delta, val, top, lft, n, wid, hgt;
    bit              absolute, unk, fend;
    pixel_rec_t      found [15];
    wid = eff_width(width_reg);
    hgt = eff_height(height_reg);
    if (req.fs) restart_position();
    bits_held  = {bits_held[6:0], req.data};
    bits_avail = bits_avail + 4'd8;
    n = 0;
    while (n < 15) begin
      if (bits_avail >= 8) head = 8'(bits_held >> (bits_avail - 8));
      else head = 8'(bits_held << (8 - bits_avail));
      absolute = 1'b0;
      unk      = 1'b0;
      delta    = 0;
      len      = 8;
      if (row_pos < 2 && col_pos < 2) begin
        delta    = int'(head);
        absolute = 1'b1;
      end else begin
        casez (head)
          8'b0???????: len = 1;
          8'b100?????: begin len = 3; delta = 4; end
          8'b101?????: begin len = 3; delta = -4; end
          8'b1101????: begin len = 4; delta = 11; end
          8'b1111????: begin len = 4; delta = -11; end
          8'b11001???: begin len = 5; delta = 20; end
          8'b110000??: begin len = 6; delta = -20; end
          8'b110001??: unk = 1'b1;
          default: begin
            delta    = int'({head[3:0], 4'h0});
            absolute = 1'b1;
          end
        endcase
      end
      if (len > int'(bits_avail)) break;
      bits_avail = bits_avail - 4'(len);
      bits_held  = bits_held & ((15'd1 << bits_avail) - 15'd1);
      idx = {row_pos[0], col_pos};
      val = delta;
      if (!absolute) begin
        lft = int'(left_pair[15:8]);
        if (col_pos < 2) begin
          top = int'(line_mem[idx]);
          val = val + top;
        end else if (row_pos < 2) begin
          val = val + lft;
        end else begin
          top = int'(line_mem[idx]);
          val = val + (top + lft) / 2;
        end
      end
      if (val < 0) val = 0;
      if (val > 255) val = 255;
      pix = 8'(val);
      line_mem[idx] = pix;
      left_pair = {left_pair[7:0], pix};
      fend = 1'b0;
      if (int'(col_pos) + 1 >= wid) begin
        col_pos = '0;
        if (int'(row_pos) + 1 >= hgt) fend = 1'b1;
        else row_pos = row_pos + 1'b1;
      end else begin
        col_pos = col_pos + 1'b1;
      end
      found[n] = '{pix, unk, fend, 1'b0};
      n++;
      if (fend) begin
        restart_position();
        break;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) found[i].last = 1'b1;
      pixel_expected.push_back(found[i]);
    end
  endtask

  // stream construction
  task automatic push_bits(input logic [7:0] v, input int nbits);
    for (int i = nbits - 1; i >= 0; i--) stream_bits.push_back(v[i]);
  endtask

  task automatic push_code(input code_kind_t kind);
    case (kind)
      CODE_ZERO:    push_bits(8'b0, 1);
      CODE_PLUS4:   push_bits(8'b100, 3);
      CODE_MINUS4:  push_bits(8'b101, 3);
      CODE_PLUS11:  push_bits(8'b1101, 4);
      CODE_MINUS11: push_bits(8'b1111, 4);
      CODE_PLUS20:  push_bits(8'b11001, 5);
      CODE_MINUS20: push_bits(8'b110000, 6);
      CODE_UNKNOWN: push_bits({6'b110001, 2'($urandom_range(0, 3))}, 8);
      default:      push_bits({4'b1110, 4'($urandom_range(0, 15))}, 8);
    endcase
  endtask

  // Pad to a byte boundary and hand the bytes to the driver.
  task automatic flush_stream(input bit first_fs, input int fs_odds, output int count);
    byte_req_t r;
    while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'($urandom_range(0, 1)));
    @(posedge clk);
    count = 0;
    while (stream_bits.size() != 0) begin
      for (int i = 7; i >= 0; i--) r.data[i] = stream_bits.pop_front();
      if (count == 0) r.fs = first_fs;
      else r.fs = (fs_odds > 0) && ($urandom_range(1, fs_odds) == 1);
      byte_pending.push_back(r);
      count++;
    end
    bytes_queued += count;
  endtask

  task automatic write_reg(input logic index, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value[10:0];
    if (index == bvd_pkg::REG_IMAGE_WIDTH) width_reg = value[10:0];
    else height_reg = value[10:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (bytes_done != bytes_queued || pixel_expected.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic log_error(input string msg);
    if (fail_count < 10) $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // input driver
  always @(posedge clk) req_taken <= rst_n && in_valid && !in_stall;

  always @(negedge clk) begin : driver
    if (req_taken) begin
      decode_request(drv_item);
      bytes_done <= bytes_done + 1;
      if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 17);
    end
    if (!in_valid || req_taken) begin
      if (gap_left > 0 || byte_pending.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        drv_item = byte_pending.pop_front();
        in_valid       <= 1'b1;
        in_stream_byte <= drv_item.data;
        in_frame_start <= drv_item.fs;
      end
    end
  end

  // long hold-off of the result side, once
  always @(negedge clk) begin : hold_gen
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  always @(negedge clk) begin : stall_gen
    if (stall_left > 0) stall_left--;
    else if (!calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 17);
    out_stall <= (stall_left > 0) || (hold_left != 0);
  end

  // result monitor
  pixel_rec_t mon_exp;

  always @(posedge clk) begin : monitor
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_expected.size() == 0) begin
        log_error($sformatf("unexpected pixel %0d unk %0b end %0b last %0b",
                            out_pixel, out_unknown_code, out_frame_end, out_last));
      end else begin
        mon_exp = pixel_expected.pop_front();
        if (out_pixel !== mon_exp.pixel || out_unknown_code !== mon_exp.unk ||
            out_frame_end !== mon_exp.fend || out_last !== mon_exp.last) begin
          log_error($sformatf("pixel exp %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
                              mon_exp.pixel, mon_exp.unk, mon_exp.fend, mon_exp.last,
                              out_pixel, out_unknown_code, out_frame_end, out_last));
        end
      end
    end
  end

  initial begin : watchdog
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int pick_width();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 3);
      1:       return $urandom_range(1025, 2047);
      2:       return 1024;
      3:       return 4;
      default: return $urandom_range(5, 12);
    endcase
  endfunction

  function automatic int pick_height();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1);
      1:       return $urandom_range(1025, 2047);
      2:       return 1024;
      default: return $urandom_range(2, 5);
    endcase
  endfunction

  initial begin : main
    int cnt, rand_bytes, phase, nb, nw, nh, k, rep;
    bit fs;
    code_kind_t kind;
    rand_bytes = 0;
    phase = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // smallest frame, both registers below range
    write_reg(bvd_pkg::REG_IMAGE_WIDTH, 0);
    write_reg(bvd_pkg::REG_IMAGE_HEIGHT, 0);
    push_bits(8'd255, 8); push_bits(8'd0, 8);
    push_code(CODE_PLUS20); push_code(CODE_MINUS20);   // clamp high, clamp low
    push_bits(8'd0, 8); push_bits(8'd255, 8);
    push_code(CODE_ABS); push_code(CODE_UNKNOWN);
    push_bits(8'hFF, 5);                               // dropped after frame end
    push_bits(8'd128, 8); push_bits(8'd128, 8);        // next frame, no restart flag
    push_code(CODE_PLUS4); push_code(CODE_MINUS4);
    push_bits(8'd1, 8); push_bits(8'd2, 8);
    push_code(CODE_PLUS11); push_code(CODE_MINUS11);
    flush_stream(1'b1, 0, cnt);
    wait_drained();

    // both registers above range, then shrink mid-row
    write_reg(bvd_pkg::REG_IMAGE_WIDTH, 2047);
    write_reg(bvd_pkg::REG_IMAGE_HEIGHT, 2047);
    push_bits(8'd10, 8); push_bits(8'd20, 8);
    repeat (40) push_code(CODE_ZERO);
    flush_stream(1'b1, 0, cnt);
    wait_drained();
    write_reg(bvd_pkg::REG_IMAGE_WIDTH, 4);
    write_reg(bvd_pkg::REG_IMAGE_HEIGHT, 3);
    push_code(CODE_ZERO);                              // ends row 0 at once
    push_bits(8'd200, 8); push_bits(8'd50, 8);
    push_code(CODE_PLUS20); push_code(CODE_MINUS11);
    push_code(CODE_PLUS4); push_code(CODE_MINUS4);
    push_code(CODE_ZERO); push_code(CODE_ABS);
    flush_stream(1'b0, 0, cnt);

    while (rand_bytes < 130) begin
      wait_drained();
      nw = pick_width();
      nh = pick_height();
      // a wider row needs a fresh frame so rows above are always written
      fs = (eff_width(nw[10:0]) > eff_width(width_reg)) || ($urandom_range(0, 3) == 0);
      write_reg(bvd_pkg::REG_IMAGE_WIDTH, nw);
      write_reg(bvd_pkg::REG_IMAGE_HEIGHT, nh);
      nb = (phase == 3) ? 40 : $urandom_range(6, 20);
      while (stream_bits.size() < nb * 8) begin
        k = $urandom_range(0, 19);
        if (k < 3) begin
          push_bits(8'($urandom_range(0, 255)), 8);
        end else begin
          if (k < 10) kind = CODE_ZERO;
          else kind = code_kind_t'($urandom_range(0, 8));
          rep = $urandom_range(1, 8);
          repeat (rep) push_code(kind);
        end
      end
      if (rand_bytes >= 100) calm = 1'b1;
      if (phase == 3) hold_req = 1'b1;
      flush_stream(fs, 40, cnt);
      rand_bytes += cnt;
      phase++;
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bvd_pkg.sv
rtl/bayer_vlc_dpcm_decoder_core.sv
tb/tb_bayer_vlc_dpcm_decoder_core.sv
